@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/isibd_pkg.sv @@
// ---------------------------------------------------------------------------
// ISI burst detector package
// Field widths, fixed constants and the controller to datapath interface.
// ---------------------------------------------------------------------------
package isibd_pkg;

  localparam int TIME_W     = 32;
  localparam int THR_W      = 16;
  localparam int BCNT_W     = 16;
  localparam int RATE_W     = 34;
  localparam int MS_PER_S   = 1000;
  localparam int MS_W       = 10;
  localparam int FRAC_BITS  = 8;
  localparam int MIN_SPIKES = 3;
  localparam int RUN_START  = 2;

  localparam logic [THR_W-1:0]  THR_RESET = 16'd5;
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  typedef struct packed {
    logic accept;    // take the offered spike into the train state
    logic finish;    // close the train and latch its totals
    logic mul;       // scale the selected total by the ms-per-second factor
    logic load;      // load the divider from the product
    logic step;      // one restoring division step
    logic store;     // keep the saturated quotient
    logic sel;       // 0: burst total, 1: tonic total
    logic out_load;  // move the finished result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;   // the train has enough spikes and a non-zero span
    logic step_last;  // the division is on its final step
  } dp_status_t;

endpackage

@@ hdl/isibd_datapath.sv @@
// ---------------------------------------------------------------------------
// ISI burst detector datapath
// Train state, run bookkeeping, rate scaling and a shared bit-serial divider.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isibd_datapath import isibd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i,
  input  logic [TIME_W-1:0] spike_time_i,
  output logic [BCNT_W-1:0] burst_num_o,
  output logic [RATE_W-1:0] burst_rate_o,
  output logic [RATE_W-1:0] tonic_rate_o
);

  localparam int PROD_W = COUNT_BITS + MS_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
    sat_inc = sat_add(a, COUNT_BITS'(1));
  endfunction

  logic [THR_W-1:0]      thr_q, thr_d;
  logic [TIME_W-1:0]     prev_q, prev_d, first_q, first_d;
  logic [COUNT_BITS-1:0] total_q, total_d, run_q, run_d;
  logic                  in_run_q, in_run_d;
  logic [COUNT_BITS-1:0] bursts_q, bursts_d, btot_q, btot_d, ttot_q, ttot_d;

  logic [COUNT_BITS-1:0] fin_bursts_q, fin_bursts_d, fin_btot_q, fin_btot_d;
  logic [COUNT_BITS-1:0] fin_ttot_q, fin_ttot_d;
  logic [TIME_W-1:0]     span_q, span_d;

  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [TIME_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [RATE_W-1:0]     rate_b_q, rate_b_d, rate_t_q, rate_t_d;

  logic [BCNT_W-1:0]     bcnt_out_q, bcnt_out_d;
  logic [RATE_W-1:0]     brate_out_q, brate_out_d, trate_out_q, trate_out_d;

  logic [TIME_W-1:0]     isi;
  logic                  isi_short;
  logic                  run_is_burst;
  logic [COUNT_BITS-1:0] tonic_base;
  logic [TIME_W-1:0]     span_now;
  logic                  train_short;
  logic [COUNT_BITS-1:0] close_bursts, close_btot, close_ttot;
  logic [TIME_W:0]       trial;
  logic                  trial_ge;
  logic [63:0]           quo_ext;
  logic [RATE_W-1:0]     quo_sat;

  assign isi          = spike_time_i - prev_q;
  assign isi_short    = isi < TIME_W'(thr_q);
  assign run_is_burst = run_q >= COUNT_BITS'(MIN_SPIKES);
  assign span_now     = prev_q - first_q;
  assign train_short  = total_q < COUNT_BITS'(MIN_SPIKES);

  assign status_o.need_div  = !train_short && (span_now != '0);
  assign status_o.step_last = (step_q == '0);

  // An open run at the end of the train is closed before the totals are taken.
  always_comb begin
    close_bursts = bursts_q;
    close_btot   = btot_q;
    close_ttot   = ttot_q;
    if (in_run_q) begin
      if (run_is_burst) begin
        close_bursts = sat_inc(bursts_q);
        close_btot   = sat_add(btot_q, run_q);
      end else begin
        close_ttot   = sat_add(ttot_q, run_q);
      end
    end
  end

  assign trial    = {rem_q, num_q[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, span_q};
  assign quo_ext  = 64'(num_q);
  assign quo_sat  = (quo_ext > 64'(RATE_MAX)) ? RATE_MAX : quo_ext[RATE_W-1:0];

  always_comb begin
    thr_d        = thr_q;
    prev_d       = prev_q;
    first_d      = first_q;
    total_d      = total_q;
    run_d        = run_q;
    in_run_d     = in_run_q;
    bursts_d     = bursts_q;
    btot_d       = btot_q;
    ttot_d       = ttot_q;
    fin_bursts_d = fin_bursts_q;
    fin_btot_d   = fin_btot_q;
    fin_ttot_d   = fin_ttot_q;
    span_d       = span_q;
    prod_d       = prod_q;
    num_d        = num_q;
    rem_d        = rem_q;
    step_d       = step_q;
    rate_b_d     = rate_b_q;
    rate_t_d     = rate_t_q;
    bcnt_out_d   = bcnt_out_q;
    brate_out_d  = brate_out_q;
    trate_out_d  = trate_out_q;
    tonic_base   = ttot_q;

    if (cfg_we_i) begin
      thr_d = cfg_wdata_i;
    end

    if (cmd_i.accept) begin
      prev_d  = spike_time_i;
      total_d = sat_inc(total_q);
      if (total_q == '0) begin
        first_d = spike_time_i;
      end else if (isi_short) begin
        if (!in_run_q) begin
          in_run_d = 1'b1;
          run_d    = COUNT_BITS'(RUN_START);
        end else begin
          run_d    = sat_inc(run_q);
        end
      end else begin
        // A long interval closes any open run and itself counts one tonic spike.
        if (in_run_q) begin
          if (run_is_burst) begin
            bursts_d = sat_inc(bursts_q);
            btot_d   = sat_add(btot_q, run_q);
          end else begin
            tonic_base = sat_add(ttot_q, run_q);
          end
          in_run_d = 1'b0;
          run_d    = '0;
        end
        ttot_d = sat_inc(tonic_base);
      end
    end

    if (cmd_i.finish) begin
      fin_bursts_d = train_short ? '0 : close_bursts;
      fin_btot_d   = close_btot;
      fin_ttot_d   = close_ttot;
      span_d       = span_now;
      rate_b_d     = '0;
      rate_t_d     = '0;
      prev_d       = '0;
      first_d      = '0;
      total_d      = '0;
      in_run_d     = 1'b0;
      run_d        = '0;
      bursts_d     = '0;
      btot_d       = '0;
      ttot_d       = '0;
    end

    if (cmd_i.mul) begin
      prod_d = PROD_W'(cmd_i.sel ? fin_ttot_q : fin_btot_q) * PROD_W'(MS_PER_S);
    end

    if (cmd_i.load) begin
      num_d  = {prod_q, FRAC_BITS'(0)};
      rem_d  = '0;
      step_d = STEP_W'(NUM_W - 1);
    end

    if (cmd_i.step) begin
      num_d  = {num_q[NUM_W-2:0], trial_ge};
      rem_d  = trial_ge ? TIME_W'(trial - {1'b0, span_q}) : trial[TIME_W-1:0];
      step_d = step_q - STEP_W'(1);
    end

    if (cmd_i.store) begin
      if (cmd_i.sel) begin
        rate_t_d = quo_sat;
      end else begin
        rate_b_d = quo_sat;
      end
    end

    if (cmd_i.out_load) begin
      bcnt_out_d  = BCNT_W'(fin_bursts_q);
      brate_out_d = rate_b_q;
      trate_out_d = rate_t_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      prev_q   <= '0;
      first_q  <= '0;
      total_q  <= '0;
      run_q    <= '0;
      in_run_q <= 1'b0;
      bursts_q <= '0;
      btot_q   <= '0;
      ttot_q   <= '0;
      step_q   <= '0;
    end else begin
      thr_q    <= thr_d;
      prev_q   <= prev_d;
      first_q  <= first_d;
      total_q  <= total_d;
      run_q    <= run_d;
      in_run_q <= in_run_d;
      bursts_q <= bursts_d;
      btot_q   <= btot_d;
      ttot_q   <= ttot_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_bursts_q <= fin_bursts_d;
    fin_btot_q   <= fin_btot_d;
    fin_ttot_q   <= fin_ttot_d;
    span_q       <= span_d;
    prod_q       <= prod_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    rate_b_q     <= rate_b_d;
    rate_t_q     <= rate_t_d;
    bcnt_out_q   <= bcnt_out_d;
    brate_out_q  <= brate_out_d;
    trate_out_q  <= trate_out_d;
  end

  assign burst_num_o  = bcnt_out_q;
  assign burst_rate_o = brate_out_q;
  assign tonic_rate_o = trate_out_q;

  `ASSERT_NEXT(a_train_cleared, cmd_i.finish, (total_q == '0) && !in_run_q, "train state not cleared after the last spike")
  `ASSERT_ALWAYS(a_run_open_size, !in_run_q || (run_q >= COUNT_BITS'(RUN_START)), "open run holds fewer than two spikes")

endmodule

@@ hdl/isibd_ctrl.sv @@
// ---------------------------------------------------------------------------
// ISI burst detector controller
// Sequences spike intake, train close, the two rate divisions and the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isibd_ctrl import isibd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       last_spike_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIN   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (last_spike_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        sel_d        = 1'b0;
        state_d      = status_i.need_div ? ST_MUL : ST_WAIT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (sel_q) begin
          state_d = ST_WAIT;
        end else begin
          sel_d   = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_WAIT: begin
        // The previous result must have left the output register first.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.sel = sel_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_ALWAYS(a_no_overwrite, !(cmd_o.out_load && out_valid_q && out_stall_i), "pending result overwritten")
  `ASSERT_NEXT(a_short_skips_div, (state_q == ST_FIN) && !status_i.need_div, state_q == ST_WAIT, "train without a division did not go to the result")
  `ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && status_i.step_last, state_q == ST_STORE, "division did not end on its last step")
  `ASSERT_NEXT(a_result_shown, cmd_o.out_load, out_valid_q, "loaded result not offered")

endmodule

@@ hdl/isi_burst_detector_unit.sv @@
// ---------------------------------------------------------------------------
// ISI burst detector
// Counts bursts and tonic spikes in a spike train and reports their rates.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   spike_time_i, last_spike_i
// out       output     out_valid_o / out_stall_i burst_num_o, burst_rate_o,
//                                                tonic_rate_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_wdata_i (ISI threshold, ms)
//
// A spike that is not the last of its train is taken at once while idle.
// The last spike holds the input through the train close, the rate
// computation (one restoring divider stepping one quotient bit per cycle, run
// once per rate, skipped on a short train or a zero span) and the result load.
// The result sits in an output register, so a stalled output holds back only
// the following last spike. Reset restores the threshold of 5 ms.
// ---------------------------------------------------------------------------
module isi_burst_detector_unit import isibd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] spike_time_i,
  input  logic              last_spike_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BCNT_W-1:0] burst_num_o,
  output logic [RATE_W-1:0] burst_rate_o,
  output logic [RATE_W-1:0] tonic_rate_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [THR_W-1:0]  cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  isibd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .last_spike_i (last_spike_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  isibd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .spike_time_i  (spike_time_i),
    .burst_num_o   (burst_num_o),
    .burst_rate_o  (burst_rate_o),
    .tonic_rate_o  (tonic_rate_o)
  );

endmodule

@@ test/isi_burst_detector_unit_tb.sv @@
// ---------------------------------------------------------------------------
// ISI burst detector testbench
// Feeds spike trains into the detector and predicts every train summary in a
// scoreboard. Each summary the block returns is compared field by field. The
// run covers short trains, zero spans, wrapped times and several thresholds,
// with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module isi_burst_detector_unit_tb;
  import isibd_pkg::*;

  localparam int COUNT_BITS      = 16;
  localparam int DIV_LATENCY     = 2 * COUNT_BITS + 44;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_SPIKES    = 140;

  typedef struct packed {
    logic [BCNT_W-1:0] count;
    logic [RATE_W-1:0] burst_rate;
    logic [RATE_W-1:0] tonic_rate;
  } train_summary_t;

  class train_scoreboard;
    logic [THR_W-1:0]  threshold;
    logic [TIME_W-1:0] prev_time;
    logic [TIME_W-1:0] first_time;
    longint unsigned   spikes;
    longint unsigned   run_len;
    longint unsigned   bursts;
    longint unsigned   burst_spikes;
    longint unsigned   tonic_spikes;
    bit                run_open;
    train_summary_t    summary_q[$];
    int unsigned       mismatches;

    function new();
      threshold  = THR_RESET;
      mismatches = 0;
      clear_train();
    endfunction

    function void clear_train();
      prev_time    = '0;
      first_time   = '0;
      spikes       = 0;
      run_len      = 0;
      bursts       = 0;
      burst_spikes = 0;
      tonic_spikes = 0;
      run_open     = 1'b0;
    endfunction

    function longint unsigned clip_add(input longint unsigned a, input longint unsigned b);
      longint unsigned ceiling;
      ceiling = (64'd1 << COUNT_BITS) - 1;
      return (a + b > ceiling) ? ceiling : a + b;
    endfunction

    function logic [RATE_W-1:0] rate_q8(input longint unsigned count,
                                        input logic [TIME_W-1:0] span);
      longint unsigned q;
      if (span == '0) return '0;
      q = (count * (longint'(MS_PER_S) << FRAC_BITS)) / span;
      return (q > RATE_MAX) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    // A run of three or more spikes is a burst; a shorter one counts as tonic.
    function void close_run();
      if (run_len >= MIN_SPIKES) begin
        bursts       = clip_add(bursts, 1);
        burst_spikes = clip_add(burst_spikes, run_len);
      end else begin
        tonic_spikes = clip_add(tonic_spikes, run_len);
      end
      run_open = 1'b0;
      run_len  = 0;
    endfunction

    function void take_spike(input logic [TIME_W-1:0] t, input logic last);
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] span;
      train_summary_t    s;
      if (spikes == 0) begin
        first_time = t;
      end else begin
        interval = t - prev_time;
        if (interval < threshold) begin
          if (!run_open) begin
            run_open = 1'b1;
            run_len  = RUN_START;
          end else begin
            run_len = clip_add(run_len, 1);
          end
        end else begin
          if (run_open) close_run();
          tonic_spikes = clip_add(tonic_spikes, 1);
        end
      end
      prev_time = t;
      spikes    = clip_add(spikes, 1);
      if (!last) return;
      if (spikes < MIN_SPIKES) begin
        s = '0;
      end else begin
        if (run_open) close_run();
        span         = t - first_time;
        s.count      = bursts[BCNT_W-1:0];
        s.burst_rate = rate_q8(burst_spikes, span);
        s.tonic_rate = rate_q8(tonic_spikes, span);
      end
      summary_q.push_back(s);
      clear_train();
    endfunction

    function void compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_summary(input logic [BCNT_W-1:0] count,
                                input logic [RATE_W-1:0] burst_rate,
                                input logic [RATE_W-1:0] tonic_rate);
      train_summary_t want;
      if (summary_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual count %0d rates %0d %0d",
                 $time, count, burst_rate, tonic_rate);
        return;
      end
      want = summary_q.pop_front();
      compare_field("burst_num", want.count, count);
      compare_field("burst_rate", want.burst_rate, burst_rate);
      compare_field("tonic_rate", want.tonic_rate, tonic_rate);
    endfunction

    function int unsigned pending();
      return summary_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [TIME_W-1:0] spike_time_i;
  logic              last_spike_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BCNT_W-1:0] burst_num_o;
  logic [RATE_W-1:0] burst_rate_o;
  logic [RATE_W-1:0] tonic_rate_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [THR_W-1:0]  cfg_wdata_i;

  train_scoreboard sb;
  bit              hold_off_req = 1'b0;

  isi_burst_detector_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .spike_time_i (spike_time_i),
    .last_spike_i (last_spike_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .burst_num_o  (burst_num_o),
    .burst_rate_o (burst_rate_o),
    .tonic_rate_o (tonic_rate_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // All tasks below are entered at a falling edge and return at one.
  task automatic send_spike(input logic [TIME_W-1:0] t, input logic last,
                            input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    spike_time_i <= t;
    last_spike_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_spike(t, last);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.threshold = thr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DIV_LATENCY) @(negedge clk_i);
  endtask

  // Mostly short intervals so that runs form, with the threshold boundary,
  // long gaps and arbitrary (often backwards) jumps mixed in.
  function automatic logic [TIME_W-1:0] next_interval(input logic [THR_W-1:0] thr);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (thr != '0 && pick < 9) return $urandom_range(0, thr - 1);
    if (pick < 11) return thr;
    if (thr != '0 && pick < 13) return thr - 1;
    if (pick < 18) return thr + $urandom_range(0, 40);
    return $urandom;
  endfunction

  task automatic send_random_train(inout int unsigned sent);
    int unsigned       len;
    int unsigned       pick;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 19);
    if (pick < 2) len = $urandom_range(1, 2);
    else if (pick < 4) len = $urandom_range(20, 40);
    else len = $urandom_range(3, 12);
    t = $urandom;
    for (int i = 0; i < len; i++) begin
      if (i > 0) t = t + next_interval(sb.threshold);
      send_spike(t, i == len - 1, $urandom_range(0, 5));
    end
    sent += len;
  endtask

  initial begin : result_sink
    int unsigned wait_cycles;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = $urandom_range(0, 5);
      if (hold_off_req) begin
        wait_cycles  = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_summary(burst_num_o, burst_rate_o, tonic_rate_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("isi_burst_detector_unit test failed");
    $finish;
  end

  initial begin : stimulus
    logic [THR_W-1:0]  thr;
    int unsigned       sent;
    in_valid_i   = 1'b0;
    spike_time_i = '0;
    last_spike_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_wdata_i  = '0;
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed trains under the threshold left by reset.
    send_spike(32'd100, 1'b1, $urandom_range(0, 5));
    send_spike(32'd0, 1'b0, $urandom_range(0, 5));
    send_spike(32'd3, 1'b1, $urandom_range(0, 5));
    // Equal times: one burst over a zero span.
    send_spike(32'd7, 1'b0, $urandom_range(0, 5));
    send_spike(32'd7, 1'b0, $urandom_range(0, 5));
    send_spike(32'd7, 1'b1, $urandom_range(0, 5));
    // A burst of four, then a pair that stays tonic and is closed by a long gap.
    send_spike(32'd0, 1'b0, $urandom_range(0, 5));
    send_spike(32'd1, 1'b0, $urandom_range(0, 5));
    send_spike(32'd2, 1'b0, $urandom_range(0, 5));
    send_spike(32'd3, 1'b0, $urandom_range(0, 5));
    send_spike(32'd20, 1'b0, $urandom_range(0, 5));
    send_spike(32'd21, 1'b0, $urandom_range(0, 5));
    send_spike(32'd40, 1'b1, $urandom_range(0, 5));
    // Times that wrap through zero, an interval equal to the threshold and a
    // backwards step.
    send_spike(32'hFFFF_FFFE, 1'b0, $urandom_range(0, 5));
    send_spike(32'hFFFF_FFFF, 1'b0, $urandom_range(0, 5));
    send_spike(32'd3, 1'b0, $urandom_range(0, 5));
    send_spike(32'd8, 1'b0, $urandom_range(0, 5));
    send_spike(32'd2, 1'b1, $urandom_range(0, 5));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: thr = '0;
        1: thr = '1;
        2: thr = $urandom_range(1, 12);
        default: begin
          if ($urandom_range(0, 1) == 0) thr = $urandom_range(1, 40);
          else thr = $urandom_range(0, 65535);
        end
      endcase
      write_threshold(thr);
      // Hold results back for a long stretch so that the block fills up.
      if (p == 3) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PHASE_SPIKES) send_random_train(sent);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("isi_burst_detector_unit test passed");
    end else begin
      $display("isi_burst_detector_unit test failed");
    end
    $finish;
  end

endmodule
